@@ src/grb_pkg.sv @@
// Shared types and constants for the generation ring buffer.
package grb_pkg;

  localparam int MSG_W         = 64;
  localparam int GEN_W         = 32;
  localparam int CFG_W         = 5;
  localparam int DIV_STEPS     = GEN_W;
  localparam int MAX_SLOTS_DEF = 16;
  localparam int MSG_BITS_DEF  = 64;

  localparam logic OP_PUBLISH = 1'b0;
  localparam logic OP_READ    = 1'b1;

  typedef struct packed {
    logic             op;
    logic [MSG_W-1:0] message_in;
    logic [GEN_W-1:0] reader_generation;
  } in_t;

  typedef struct packed {
    logic             ok;
    logic [MSG_W-1:0] message_out;
    logic [GEN_W-1:0] new_generation;
  } out_t;

  typedef struct packed {
    logic capture;
    logic clamp;
    logic div_init;
    logic div_step;
    logic mem_access;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

@@ src/generation_ring_buffer_unit.sv @@
// Top level of the generation ring buffer: controller, datapath and slot RAM.
//
//   channel  | signals                      | direction | payload
//   ---------+------------------------------+-----------+-----------------------------
//   in       | in_valid_i / in_ready_o      | in        | in_t: op, message, generation
//   out      | out_valid_o / out_ready_i    | out       | out_t: ok, message, generation
//   cfg      | cfg_we_i                     | in        | queue size, 5 bits
//
// Every beat runs from acceptance to a loaded result through clamp, step-back,
// the bit-serial slot modulo, one RAM access and the result load.
// The slot modulo divides by the ring size bit-serially.
// A new beat is accepted while the previous result waits in the output register;
// a stalled output only holds the controller in its final state.
// Reset (async, active low) clears the count, the data flag and the queue size to 1.
module generation_ring_buffer_unit import grb_pkg::*; #(
  parameter int MaxSlots = MAX_SLOTS_DEF,
  parameter int MsgBits  = MSG_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  grb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  grb_dp #(
    .MaxSlots(MaxSlots),
    .MsgBits (MsgBits)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_o      (out_o)
  );

endmodule

@@ src/grb_ram.sv @@
// Generic single-port-write, registered-read RAM.
module grb_ram #(
  parameter int Width = 64,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/grb_dp.sv @@
// Datapath: beat capture, generation clamp, bit-serial modulo, slot RAM, result register.
module grb_dp import grb_pkg::*; #(
  parameter int MaxSlots = MAX_SLOTS_DEF,
  parameter int MsgBits  = MSG_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  in_t              in_i,
  input  ctrl_cmd_t        cmd_i,
  output dp_status_t       status_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output out_t             out_o
);

  localparam int QW    = $clog2(MaxSlots + 1);
  localparam int SlotW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;

  logic [CFG_W-1:0]   qcfg_q;
  logic [QW-1:0]      q_eff;
  logic [GEN_W-1:0]   q_wide;

  logic [GEN_W-1:0]   cur_q, cur_d;
  logic               has_data_q, has_data_d;
  logic               op_q;
  logic [MsgBits-1:0] msg_q;
  logic [GEN_W-1:0]   gen_q, gen_d;
  logic [GEN_W-1:0]   dvd_q, dvd_d;
  logic [QW-1:0]      rem_q, rem_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;

  logic [GEN_W-1:0]   gen_plus_size;
  logic [GEN_W-1:0]   gen_back;
  logic [QW:0]        shifted;
  logic [QW:0]        trial;
  logic [SlotW-1:0]   slot;
  logic [MsgBits-1:0] rdata;
  logic               ram_we;
  logic               ram_re;

  // Effective ring size: zero acts as one, oversize saturates.
  always_comb begin
    if (qcfg_q == '0) begin
      q_eff = QW'(1);
    end else if (GEN_W'(qcfg_q) > GEN_W'(MaxSlots)) begin
      q_eff = QW'(MaxSlots);
    end else begin
      q_eff = QW'(qcfg_q);
    end
  end

  assign q_wide        = GEN_W'(q_eff);
  assign gen_plus_size = gen_q + q_wide;
  assign gen_back      = ((cur_q == gen_q) && (gen_q != '0)) ? gen_q - GEN_W'(1) : gen_q;
  assign shifted       = {rem_q, dvd_q[GEN_W-1]};
  assign trial         = shifted - {1'b0, q_eff};
  assign slot          = rem_q[SlotW-1:0];
  assign ram_we        = cmd_i.mem_access && (op_q == OP_PUBLISH);
  assign ram_re        = cmd_i.mem_access && (op_q == OP_READ);

  grb_ram #(
    .Width(MsgBits),
    .Depth(MaxSlots)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(slot),
    .wdata_i(msg_q),
    .re_i   (ram_re),
    .raddr_i(slot),
    .rdata_o(rdata)
  );

  always_comb begin
    gen_d = gen_q;
    dvd_d = dvd_q;
    rem_d = rem_q;
    if (cmd_i.capture) begin
      gen_d = in_i.reader_generation;
    end
    // Clamp and step-back only matter once data exists; otherwise the raw
    // generation is echoed back.
    if (cmd_i.clamp && has_data_q && (cur_q > gen_plus_size)) begin
      gen_d = cur_q - q_wide;
    end
    if (cmd_i.div_init) begin
      rem_d = '0;
      if (op_q == OP_READ) begin
        if (has_data_q) begin
          gen_d = gen_back;
        end
        dvd_d = has_data_q ? gen_back : gen_q;
      end else begin
        dvd_d = cur_q;
      end
    end
    if (cmd_i.div_step) begin
      rem_d = trial[QW] ? shifted[QW-1:0] : trial[QW-1:0];
      dvd_d = {dvd_q[GEN_W-2:0], 1'b0};
    end
  end

  always_comb begin
    cur_d       = cur_q;
    has_data_d  = has_data_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
      if (op_q == OP_PUBLISH) begin
        cur_d                = cur_q + GEN_W'(1);
        has_data_d           = 1'b1;
        out_d.ok             = 1'b1;
        out_d.message_out    = '0;
        out_d.new_generation = cur_q + GEN_W'(1);
      end else if (!has_data_q) begin
        out_d.ok             = 1'b0;
        out_d.message_out    = '0;
        out_d.new_generation = gen_q;
      end else begin
        out_d.ok          = 1'b1;
        out_d.message_out = MSG_W'(rdata);
        if (q_eff == QW'(1)) begin
          out_d.new_generation = cur_q;
        end else if (gen_q < cur_q) begin
          out_d.new_generation = gen_q + GEN_W'(1);
        end else begin
          out_d.new_generation = gen_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qcfg_q      <= CFG_W'(1);
      cur_q       <= '0;
      has_data_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        qcfg_q <= cfg_wdata_i;
      end
      cur_q       <= cur_d;
      has_data_q  <= has_data_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= in_i.op;
      msg_q <= in_i.message_in[MsgBits-1:0];
    end
    gen_q <= gen_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    out_q <= out_d;
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_o             = out_q;

  // A finished result never overwrites one still waiting downstream.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // The remainder addressing the RAM is a valid ring slot.
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mem_access |-> (rem_q < q_eff))
    else $error("slot index outside ring");

  // Each completed publish advances the count by exactly one.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && (op_q == OP_PUBLISH)) |=> (cur_q == $past(cur_q) + GEN_W'(1)))
    else $error("publish count did not advance");

endmodule

@@ src/grb_ctrl.sv @@
// Controller: sequences capture, clamp, modulo steps, RAM access and result load.
module grb_ctrl import grb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam int CntW = $clog2(DIV_STEPS);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CLAMP = 6'b000010,
    ST_STEP  = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_MEM   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            last_step;

  assign last_step  = (cnt_q == CntW'(DIV_STEPS - 1));
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        cmd_o.clamp = 1'b1;
        state_d     = ST_STEP;
      end
      ST_STEP: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CntW'(1);
        if (last_step) begin
          state_d = ST_MEM;
        end
      end
      ST_MEM: begin
        cmd_o.mem_access = 1'b1;
        state_d          = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_CLAMP))
    else $error("accepted beat did not start processing");

  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DIV) && last_step) |=> (state_q == ST_MEM))
    else $error("modulo did not end after its last step");

endmodule

@@ verif/generation_ring_buffer_unit_tb.sv @@
// Self-checking testbench for the generation ring buffer: directed and random beats.
module generation_ring_buffer_unit_tb import grb_pkg::*; ();

  localparam int          NUM_PHASES      = 22;
  localparam int          ITEMS_PER_PHASE = 85;
  localparam int          WATCHDOG_LIMIT  = 1500;
  localparam int          DRAIN_CYCLES    = 60;
  localparam logic [63:0] MSG_PATTERN     = 64'hA5A5_5A5A_0FF0_F00F;

  // Ring model: publish counter, slot contents and the results still owed.
  class ring_scoreboard;
    logic [GEN_W-1:0] pub_count;
    bit               has_msg;
    logic [CFG_W-1:0] qsize_reg;
    logic [MSG_W-1:0] slot_copy [MAX_SLOTS_DEF];
    bit               slot_written [MAX_SLOTS_DEF];
    out_t             pending_results [$];
    int               errors;

    function new();
      pub_count = '0;
      has_msg   = 1'b0;
      qsize_reg = CFG_W'(1);
      errors    = 0;
      foreach (slot_written[i]) slot_written[i] = 1'b0;
    endfunction

    function int unsigned ring_depth();
      if (qsize_reg == 0) return 1;
      if (qsize_reg > MAX_SLOTS_DEF) return MAX_SLOTS_DEF;
      return qsize_reg;
    endfunction

    // Result of one beat against the current state; slot is the entry touched, -1 if none.
    function out_t next_result(in_t b, output int slot);
      out_t             res;
      logic [GEN_W-1:0] q;
      logic [GEN_W-1:0] gen;
      logic [GEN_W-1:0] lim;
      q    = GEN_W'(ring_depth());
      gen  = b.reader_generation;
      res  = '0;
      slot = -1;
      if (b.op == OP_PUBLISH) begin
        slot               = int'(pub_count % q);
        res.ok             = 1'b1;
        res.new_generation = pub_count + 1'b1;
      end else if (!has_msg) begin
        res.new_generation = gen;
      end else begin
        if (q == 1) begin
          slot = 0;
          gen  = pub_count;
        end else begin
          lim = gen + q;
          if (pub_count > lim) gen = pub_count - q;
          if (pub_count == gen && gen != 0) gen = gen - 1'b1;
          slot = int'(gen % q);
          if (gen < pub_count) gen = gen + 1'b1;
        end
        res.ok             = 1'b1;
        res.message_out    = slot_copy[slot];
        res.new_generation = gen;
      end
      return res;
    endfunction

    function void note_input(in_t b);
      out_t res;
      int   slot;
      res = next_result(b, slot);
      if (b.op == OP_PUBLISH) begin
        slot_copy[slot]    = b.message_in;
        slot_written[slot] = 1'b1;
        pub_count          = pub_count + 1'b1;
        has_msg            = 1'b1;
      end
      pending_results.push_back(res);
    endfunction

    function void check_result(out_t got);
      out_t exp;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual ok=%0b msg=%h gen=%h",
                 $time, got.ok, got.message_out, got.new_generation);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (got.ok !== exp.ok) begin
        $display("%0t: ok mismatch, expected %0b actual %0b", $time, exp.ok, got.ok);
        errors++;
      end
      if (got.message_out !== exp.message_out) begin
        $display("%0t: message_out mismatch, expected %h actual %h",
                 $time, exp.message_out, got.message_out);
        errors++;
      end
      if (got.new_generation !== exp.new_generation) begin
        $display("%0t: new_generation mismatch, expected %h actual %h",
                 $time, exp.new_generation, got.new_generation);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni  = 1'b0;
  logic             cfg_we  = 1'b0;
  logic [CFG_W-1:0] cfg_wd  = '0;
  logic             in_vld  = 1'b0;
  in_t              in_pl   = '0;
  logic             out_rdy = 1'b0;
  logic             in_ready_o;
  logic             out_valid_o;
  out_t             out_o;

  ring_scoreboard   sb = new();
  bit               tx_gaps_on  = 1'b0;
  bit               rx_stall_on = 1'b0;
  int               rx_left     = 0;
  int               idle_cycles = 0;

  logic [CFG_W-1:0] ring_sizes [NUM_PHASES] = '{
    5'd3, 5'd16, 5'd1, 5'd5, 5'd0, 5'd8, 5'd31, 5'd2, 5'd12, 5'd20, 5'd7,
    5'd16, 5'd4, 5'd9, 5'd1, 5'd15, 5'd10, 5'd6, 5'd13, 5'd24, 5'd11, 5'd14
  };

  generation_ring_buffer_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wd),
    .in_valid_i  (in_vld),
    .in_ready_o  (in_ready_o),
    .in_i        (in_pl),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_rdy),
    .out_o       (out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic in_t beat_of(logic op, logic [MSG_W-1:0] msg, logic [GEN_W-1:0] gen);
    in_t b;
    b.op                = op;
    b.message_in        = msg;
    b.reader_generation = gen;
    return b;
  endfunction

  function automatic in_t random_beat();
    in_t         b;
    int unsigned q;
    int unsigned offs;
    int unsigned pick;
    q    = sb.ring_depth();
    b.op = ($urandom_range(0, 99) < 45) ? OP_PUBLISH : OP_READ;
    pick = $urandom_range(0, 9);
    if (pick == 0) b.message_in = '0;
    else if (pick == 1) b.message_in = '1;
    else b.message_in = {$urandom, $urandom};
    pick = $urandom_range(0, 19);
    if (pick < 10) begin
      // around the count: covers step-back, clamp edge and readers ahead
      offs                = $urandom_range(0, 2 * q + 6);
      b.reader_generation = sb.pub_count + GEN_W'(offs) - GEN_W'(q + 3);
    end else if (pick < 14) begin
      b.reader_generation = sb.pub_count;
    end else if (pick < 17) begin
      b.reader_generation = $urandom;
    end else if (pick == 17) begin
      b.reader_generation = '0;
    end else if (pick == 18) begin
      b.reader_generation = '1;
    end else begin
      b.reader_generation = sb.pub_count - GEN_W'(q) - GEN_W'($urandom_range(1, 3));
    end
    return b;
  endfunction

  // Drives one beat and returns at the edge that takes it; valid stays high.
  task automatic send_beat(input in_t beat);
    int   slot;
    out_t probe;
    // a read must never land on a slot that was never written
    if (beat.op == OP_READ) begin
      probe = sb.next_result(beat, slot);
      if (slot >= 0 && !sb.slot_written[slot]) beat.op = OP_PUBLISH;
    end
    in_pl  <= beat;
    in_vld <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(beat);
  endtask

  // Waits for the block to drain, then writes the ring size.
  task automatic set_ring_size(input logic [CFG_W-1:0] size);
    in_vld <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wd <= size;
    @(posedge clk_i);
    sb.qsize_reg = size;
    cfg_we <= 1'b0;
  endtask

  // Receiver: checks every accepted beat and, while stalls are on, stalls in stretches of random length.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_rdy) sb.check_result(out_o);
    if (rx_left == 0) begin
      if (rx_stall_on && $urandom_range(0, 99) < 40) begin
        out_rdy <= 1'b0;
        rx_left = $urandom_range(1, 40);
      end else begin
        out_rdy <= 1'b1;
        rx_left = $urandom_range(1, 30);
      end
    end else begin
      rx_left--;
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_vld && in_ready_o) || (out_valid_o && out_rdy)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int sent;
    int burst;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // size 1 from reset: reads before any publish echo the generation
    rx_stall_on = 1'b1;
    send_beat(beat_of(OP_READ, '1, '0));
    send_beat(beat_of(OP_READ, '0, '1));
    send_beat(beat_of(OP_PUBLISH, '1, '1));
    send_beat(beat_of(OP_PUBLISH, '0, '0));
    send_beat(beat_of(OP_READ, '1, 32'h1234_5678));
    send_beat(beat_of(OP_PUBLISH, MSG_PATTERN, '0));

    // four slots, all filled: step-back, clamp, wrap of the lag test, reader ahead
    set_ring_size(5'd4);
    send_beat(beat_of(OP_PUBLISH, ~MSG_PATTERN, '0));
    send_beat(beat_of(OP_PUBLISH, {$urandom, $urandom}, '0));
    send_beat(beat_of(OP_PUBLISH, {$urandom, $urandom}, '0));
    send_beat(beat_of(OP_PUBLISH, {$urandom, $urandom}, '0));
    send_beat(beat_of(OP_READ, '0, 32'd7));
    send_beat(beat_of(OP_READ, '0, 32'd0));
    send_beat(beat_of(OP_READ, '0, 32'd6));
    send_beat(beat_of(OP_READ, '0, '1));
    send_beat(beat_of(OP_READ, '0, 32'd100));

    // zero acts as one
    set_ring_size(5'd0);
    send_beat(beat_of(OP_READ, '0, 32'd5));

    // oversize saturates to the slot count
    set_ring_size(5'd31);
    send_beat(beat_of(OP_PUBLISH, {$urandom, $urandom}, '0));
    send_beat(beat_of(OP_READ, '0, 32'd8));
    set_ring_size(5'd17);
    send_beat(beat_of(OP_READ, '0, 32'd8));

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_ring_size(ring_sizes[p]);
      tx_gaps_on  = (p % 3) != 0;
      rx_stall_on = (p % 4) != 1;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        burst = $urandom_range(1, 16);
        for (int i = 0; i < burst && sent < ITEMS_PER_PHASE; i++) begin
          send_beat(random_beat());
          sent++;
        end
        if (tx_gaps_on) begin
          in_vld <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk_i);
        end
      end
    end

    in_vld <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
